### design/mclw_pkg.sv
`default_nettype none

package mclw_pkg;

  // fixed field widths of the item and result channels
  localparam int FIELD_W   = 11;
  localparam int CHAN_ID_W = 4;

  // limit registers
  localparam int LIMIT_W    = 16;
  localparam int NUM_LIMITS = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  // apb port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_INDEX_W = ADDR_W - 2;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_FEED = 1'b1;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_LIMIT_REMOTE      = 3'd0,
    REG_LIMIT_CALIBRATION = 3'd1,
    REG_LIMIT_HOST_API    = 3'd2,
    REG_LIMIT_IMU         = 3'd3,
    REG_LIMIT_GYRO        = 3'd4,
    REG_LIMIT_MOTOR       = 3'd5
  } reg_index_t;

  typedef logic [NUM_LIMITS-1:0][LIMIT_W-1:0] limit_array_t;

  typedef struct packed {
    logic                 kind;
    logic [CHAN_ID_W-1:0] channel;
    logic [FIELD_W-1:0]   mask;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] error_bits;
    logic               mask_all_set;
  } result_t;

endpackage

`default_nettype wire

### design/multi_channel_loss_watchdog_unit.sv
// Multi-channel loss watchdog. Each channel keeps a silence counter; a tick
// transaction (kind 0) checks all channels at once, setting a channel's error
// bit when its counter is at or above its limit and otherwise clearing the bit
// and counting up (counters saturate). A feed transaction (kind 1) zeroes the
// counter of one channel; its error bit moves only on the next tick. Every
// transaction returns one result: the error vector after the step and whether
// all bits of the mask are set. Error bits reset to all ones, limits to 100.
// Channels 0 to 4 have their own limit registers, all further channels share
// limit_motor (APB byte address 4*i for register i). Rate: one transaction per
// clock while in_stall is low; the channel state is updated in the accepting
// cycle and the result lands in an output register backed by a one-entry skid
// register, so in_stall rises only when both hold results that the sink has
// not taken.
`default_nettype none

module multi_channel_loss_watchdog_unit
  import mclw_pkg::*;
#(
  parameter int CHANNELS    = 11,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [CHAN_ID_W-1:0] channel,
  input  wire logic [FIELD_W-1:0]   mask,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [FIELD_W-1:0]   error_bits,
  output logic                      mask_all_set,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready
);

  limit_array_t limits;
  item_t        item;
  result_t      step_result;
  result_t      out_result;
  logic         accept;
  logic         buf_full;

  // the stall is a register output, no path from out_stall to in_stall
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  assign item.kind    = kind;
  assign item.channel = channel;
  assign item.mask    = mask;

  mclw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // counters and lost flags, updated once per accepted transaction
  mclw_channel_bank #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (item),
    .limits (limits),
    .result (step_result)
  );

  // output register plus skid entry
  mclw_result_buffer u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .din       (step_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (out_result),
    .full      (buf_full)
  );

  assign error_bits   = out_result.error_bits;
  assign mask_all_set = out_result.mask_all_set;

endmodule

`default_nettype wire

### design/mclw_cfg_regs.sv
`default_nettype none

module mclw_cfg_regs
  import mclw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output limit_array_t           limits
);

  logic                   wr_en;
  logic [REG_INDEX_W-1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LIMITS; k++) begin
        limits[k] <= LIMIT_RESET;
      end
    end else if (wr_en) begin
      case (reg_index)
        REG_LIMIT_REMOTE:      limits[REG_LIMIT_REMOTE]      <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_CALIBRATION: limits[REG_LIMIT_CALIBRATION] <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_HOST_API:    limits[REG_LIMIT_HOST_API]    <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_IMU:         limits[REG_LIMIT_IMU]         <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_GYRO:        limits[REG_LIMIT_GYRO]        <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_MOTOR:       limits[REG_LIMIT_MOTOR]       <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LIMIT_REMOTE:      prdata = DATA_W'(limits[REG_LIMIT_REMOTE]);
      REG_LIMIT_CALIBRATION: prdata = DATA_W'(limits[REG_LIMIT_CALIBRATION]);
      REG_LIMIT_HOST_API:    prdata = DATA_W'(limits[REG_LIMIT_HOST_API]);
      REG_LIMIT_IMU:         prdata = DATA_W'(limits[REG_LIMIT_IMU]);
      REG_LIMIT_GYRO:        prdata = DATA_W'(limits[REG_LIMIT_GYRO]);
      REG_LIMIT_MOTOR:       prdata = DATA_W'(limits[REG_LIMIT_MOTOR]);
      default:               prdata = '0;
    endcase
  end

  a_motor_limit_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && (reg_index == REG_LIMIT_MOTOR)
      |=> limits[REG_LIMIT_MOTOR] == $past(pwdata[LIMIT_W-1:0]))
    else $error("motor limit not taken from write data");

endmodule

`default_nettype wire

### design/mclw_channel_bank.sv
`default_nettype none

module mclw_channel_bank
  import mclw_pkg::*;
#(
  parameter int CHANNELS    = 11,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire item_t        item,
  input  wire limit_array_t limits,
  output result_t           result
);

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int PAD_W = CHANNELS + FIELD_W;

  logic [COUNT_WIDTH-1:0] count      [CHANNELS];
  logic [COUNT_WIDTH-1:0] count_next [CHANNELS];
  logic [CHANNELS-1:0]    lost;
  logic [CHANNELS-1:0]    lost_next;
  logic [PAD_W-1:0]       lost_pad;
  logic [PAD_W-1:0]       seen_pad;
  logic [FIELD_W-1:0]     seen;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    // the motor channels share the last limit register
    localparam int LI = (i < NUM_LIMITS - 1) ? i : NUM_LIMITS - 1;

    logic expired;
    logic fed;

    assign expired = CMP_W'(count[i]) >= CMP_W'(limits[LI]);
    assign fed     = (item.kind == KIND_FEED) && (32'(item.channel) == i);

    always_comb begin
      count_next[i] = count[i];
      lost_next[i]  = lost[i];
      if (item.kind == KIND_TICK) begin
        if (expired) begin
          lost_next[i] = 1'b1;
        end else begin
          lost_next[i] = 1'b0;
          if (count[i] != '1) begin
            count_next[i] = count[i] + 1'b1;
          end
        end
      end else if (fed) begin
        count_next[i] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        count[i] <= '0;
        lost[i]  <= 1'b1;
      end else if (step) begin
        count[i] <= count_next[i];
        lost[i]  <= lost_next[i];
      end
    end
  end

  // bits above the channel count read as zero, but count as set in the mask test
  assign lost_pad = {{FIELD_W{1'b0}}, lost_next};
  assign seen_pad = {{FIELD_W{1'b1}}, lost_next};
  assign seen     = seen_pad[FIELD_W-1:0];

  assign result.error_bits   = lost_pad[FIELD_W-1:0];
  assign result.mask_all_set = &(seen | ~item.mask);

  a_reset_lost: assert property (@(posedge clk)
    rst |=> lost == '1)
    else $error("lost flags not all set after reset");

  a_feed_keeps_lost: assert property (@(posedge clk) disable iff (rst)
    step && (item.kind == KIND_FEED) |=> $stable(lost))
    else $error("feed changed lost flags");

endmodule

`default_nettype wire

### design/mclw_result_buffer.sv
`default_nettype none

module mclw_result_buffer
  import mclw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t din,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      dout,
  output logic         full
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        dout       <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
        if (load) begin
          dout <= din;
        end
      end
    end else if (load) begin
      skid_valid <= 1'b1;
      skid_data  <= din;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stalled_load_to_skid: assert property (@(posedge clk) disable iff (rst)
    load && out_valid && out_stall |=> skid_valid)
    else $error("transaction accepted under stall was not kept");

endmodule

`default_nettype wire

### dv/multi_channel_loss_watchdog_unit_tb.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mclw_pkg::*;

  localparam int CHANNELS    = 11;
  localparam int COUNT_WIDTH = 16;

  // register slots past the limit registers, writes there must be dropped
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind     = KIND_TICK;
  logic [CHAN_ID_W-1:0] channel  = '0;
  logic [FIELD_W-1:0]   mask     = '0;

  // result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   error_bits;
  logic                 mask_all_set;

  // configuration port
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_W-1:0]    paddr   = '0;
  logic [DATA_W-1:0]    pwdata  = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // watchdog shadow state: limits, silence counters and lost vector
  logic [LIMIT_W-1:0]     limit_reg [NUM_LIMITS];
  logic [COUNT_WIDTH-1:0] silence   [CHANNELS];
  logic [CHANNELS-1:0]    lost_vec;

  // results still owed by the block, oldest first
  result_t expected_results [$];
  int      errors = 0;

  // traffic shaping, in percent per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // long receiver hold-off, counted in its own process
  event start_hold;
  logic hold_active = 1'b0;
  int   hold_span   = 0;

  multi_channel_loss_watchdog_unit #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .channel      (channel),
    .mask         (mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .error_bits   (error_bits),
    .mask_all_set (mask_all_set),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // shadow state after reset: limits at 100, counters idle, every channel lost
  initial begin
    for (int i = 0; i < NUM_LIMITS; i++) limit_reg[i] = LIMIT_RESET;
    for (int i = 0; i < CHANNELS; i++) silence[i] = '0;
    lost_vec = '1;
  end

  // one watchdog step: a tick checks every channel, a feed clears one counter
  function automatic result_t watchdog_step(input item_t it);
    result_t            res;
    logic [LIMIT_W-1:0] lim;
    logic [FIELD_W-1:0] seen;
    if (it.kind == KIND_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        // channels past the gyro all share the motor limit
        lim = (i < NUM_LIMITS - 1) ? limit_reg[i] : limit_reg[NUM_LIMITS-1];
        if (silence[i] >= lim) begin
          lost_vec[i] = 1'b1;
        end else begin
          lost_vec[i] = 1'b0;
          if (silence[i] != '1) silence[i] = silence[i] + 1'b1;
        end
      end
    end else if (it.channel < CHANNELS) begin
      // feed of an absent channel falls through here untouched
      silence[it.channel] = '0;
    end
    // mask bits above the last channel always count as set
    seen = FIELD_W'(lost_vec) | ~FIELD_W'({CHANNELS{1'b1}});
    res.error_bits   = FIELD_W'(lost_vec);
    res.mask_all_set = ((seen & it.mask) == it.mask);
    return res;
  endfunction

  // receiver stall: random per cycle, forced high during a hold-off
  always @(posedge clk) begin
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(start_hold);
      hold_active = 1'b1;
      repeat (hold_span) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // result checker, compares each accepted transaction with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, error_bits %h mask_all_set %b",
                 $time, error_bits, mask_all_set);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (error_bits !== want.error_bits) begin
          $display("%0t: error_bits expected %h actual %h",
                   $time, want.error_bits, error_bits);
          errors++;
        end
        if (mask_all_set !== want.mask_all_set) begin
          $display("%0t: mask_all_set expected %b actual %b",
                   $time, want.mask_all_set, mask_all_set);
          errors++;
        end
      end
    end
  end

  // offer one transaction, with an optional random gap, and hold it until taken
  task automatic send_item(input item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind     <= it.kind;
    channel  <= it.channel;
    mask     <= it.mask;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(watchdog_step(it));
  endtask

  task automatic send_fields(input logic k, input int ch, input int m);
    item_t it;
    it.kind    = k;
    it.channel = CHAN_ID_W'(ch);
    it.mask    = FIELD_W'(m);
    send_item(it);
  endtask

  // drop valid and wait for every owed result, then leave the input idle as slack
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup phase, access phase until pready, then an idle phase
  task automatic write_limit(input logic [REG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < NUM_LIMITS) limit_reg[idx] = val[LIMIT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short limits so channels keep flipping, now and then the extremes
  function automatic logic [DATA_W-1:0] pick_limit();
    logic [DATA_W-1:0] upper;
    upper = {$urandom_range(1) ? $urandom() : 32'h0} & ~32'hFFFF;
    case ($urandom_range(9))
      0:       return upper | 32'h0;
      1:       return upper | 32'hFFFF;
      2:       return upper | $urandom_range(9, 40);
      default: return upper | $urandom_range(1, 8);
    endcase
  endfunction

  task automatic write_random_limits();
    for (int i = 0; i < NUM_LIMITS; i++) write_limit(REG_INDEX_W'(i), pick_limit());
    write_limit($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
  endtask

  // feeds dominate so counters keep getting cleared; masks often probe set bits
  function automatic item_t random_item();
    item_t it;
    it.kind    = ($urandom_range(99) < 40) ? KIND_TICK : KIND_FEED;
    it.channel = ($urandom_range(9) == 0) ? CHAN_ID_W'($urandom_range(CHANNELS, 15))
                                          : CHAN_ID_W'($urandom_range(CHANNELS - 1));
    case ($urandom_range(19))
      0, 1, 2, 3, 4:         it.mask = '0;
      5, 6, 7:               it.mask = '1;
      8, 9, 10, 11, 12, 13:  it.mask = FIELD_W'(lost_vec) & FIELD_W'($urandom());
      default:               it.mask = FIELD_W'($urandom());
    endcase
    return it;
  endfunction

  // right after reset: all channels lost, first tick recovers them, absent feeds ignored
  task automatic test_reset_state();
    send_fields(KIND_FEED, 0, 'h7FF);
    send_fields(KIND_FEED, 15, 'h400);
    send_fields(KIND_TICK, 0, 'h7FF);
    send_fields(KIND_TICK, 9, 'h000);
    send_fields(KIND_FEED, 10, 'h001);
    settle();
  endtask

  // zero limit: every tick marks each channel lost, feeds leave the bits alone
  task automatic test_zero_limit();
    for (int i = 0; i < NUM_LIMITS; i++) write_limit(REG_INDEX_W'(i), 32'h0);
    write_limit(REG_SPARE_B, 32'h0000_FFFF);
    send_fields(KIND_TICK, 5, 'h7FF);
    send_fields(KIND_FEED, 3, 'h008);
    send_fields(KIND_TICK, 12, 'h555);
    settle();
  endtask

  // mixed limits, smallest and largest, with upper data bits that must be dropped
  task automatic test_limit_extremes();
    write_limit(REG_LIMIT_REMOTE,      32'hFFFF_0001);
    write_limit(REG_LIMIT_CALIBRATION, 32'h0000_FFFF);
    write_limit(REG_LIMIT_HOST_API,    32'h0000_0002);
    write_limit(REG_LIMIT_IMU,         32'hA5A5_0000);
    write_limit(REG_LIMIT_GYRO,        32'hFFFF_FFFF);
    write_limit(REG_LIMIT_MOTOR,       32'h0000_0001);
    write_limit(REG_SPARE_A,           32'h0000_0003);
    send_fields(KIND_FEED, 0, 'h000);
    send_fields(KIND_FEED, 5, 'h000);
    send_fields(KIND_TICK, 0, 'h7FF);
    send_fields(KIND_TICK, 0, 'h2AA);
    send_fields(KIND_TICK, 0, 'h7E9);
    send_fields(KIND_FEED, 1, 'h001);
    send_fields(KIND_FEED, 14, 'h7FF);
    send_fields(KIND_FEED, 11, 'h7FF);
    send_fields(KIND_TICK, 0, 'h7FF);
    settle();
  endtask

  task automatic random_phase(input int idle, input int stall, input int n);
    write_random_limits();
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_item(random_item());
    settle();
  endtask

  // random traffic under each idling pattern, new limits per phase
  task automatic test_random_traffic();
    random_phase(0, 0, 440);
    random_phase(74, 0, 440);
    random_phase(0, 74, 440);
    random_phase(6, 6, 440);
  endtask

  // receiver holds off long enough for the output buffers to fill and stall the input
  task automatic test_backpressure();
    write_random_limits();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_span     = 300;
    -> start_hold;
    repeat (60) send_item(random_item());
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_zero_limit();
    test_limit_extremes();
    test_random_traffic();
    test_backpressure();
    if (errors == 0) begin
      $display("multi_channel_loss_watchdog_unit verification clean");
    end else begin
      $display("multi_channel_loss_watchdog_unit verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("multi_channel_loss_watchdog_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
